>>> sv/tree_entry_stream_parser_unit_defines.svh
// Assertion macros shared by the parser modules.
`ifndef TREE_ENTRY_STREAM_PARSER_UNIT_DEFINES_SVH
`define TREE_ENTRY_STREAM_PARSER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define TESP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tesp assertion failed");
`define TESP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tesp assertion failed");
`else
`define TESP_ASSERT_SAME(label, clk, rst, ante, cons)
`define TESP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> sv/tesp_pkg.sv
`timescale 1ns / 1ps

package tesp_pkg;

   localparam int ID_BYTES_DEFAULT = 20;

   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_ZERO  = 8'h00;

   localparam logic [2:0] KIND_MODE  = 3'd0;
   localparam logic [2:0] KIND_SPACE = 3'd1;
   localparam logic [2:0] KIND_NAME  = 3'd2;
   localparam logic [2:0] KIND_ZERO  = 3'd3;
   localparam logic [2:0] KIND_ID    = 3'd4;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_NO_SPACE = 2'd1;
   localparam logic [1:0] ERR_NO_TERM  = 2'd2;
   localparam logic [1:0] ERR_TRUNC_ID = 2'd3;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] field_kind;
      logic       entry_end;
      logic [1:0] parse_error;
      logic       stream_done;
   } result_type;

endpackage

>>> sv/tesp_phase_fsm.sv
`timescale 1ns / 1ps
`include "tree_entry_stream_parser_unit_defines.svh"

module tesp_phase_fsm #(
   parameter int ID_BYTES = tesp_pkg::ID_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           data_byte,
   input  logic                 stream_last,
   output tesp_pkg::result_type result
);
   import tesp_pkg::*;

   typedef enum logic [1:0] {
      PH_MODE = 2'd0,
      PH_NAME = 2'd1,
      PH_ID   = 2'd2
   } phase_type;

   localparam logic [5:0] IdLast = 6'(ID_BYTES);

   phase_type  phase_ff, phase_in, phase_mid;
   logic       started_ff, started_in, started_mid;
   logic [4:0] id_count_ff, id_count_in, id_count_mid;
   logic [5:0] count_inc;
   logic [2:0] kind;
   logic       entry_end;
   logic [1:0] parse_error;

   assign count_inc = {1'b0, id_count_ff} + 6'd1;

   always_comb begin
      phase_mid    = phase_ff;
      started_mid  = started_ff;
      id_count_mid = id_count_ff;
      entry_end    = 1'b0;
      kind         = KIND_MODE;
      unique case (phase_ff)
         PH_NAME: begin
            if (data_byte == BYTE_ZERO) begin
               kind         = KIND_ZERO;
               phase_mid    = PH_ID;
               id_count_mid = 5'd0;
            end else begin
               kind = KIND_NAME;
            end
         end
         PH_ID: begin
            kind = KIND_ID;
            if (count_inc >= IdLast) begin
               entry_end    = 1'b1;
               phase_mid    = PH_MODE;
               started_mid  = 1'b0;
               id_count_mid = 5'd0;
            end else begin
               id_count_mid = count_inc[4:0];
            end
         end
         default: begin
            started_mid = 1'b1;
            if (data_byte == BYTE_SPACE) begin
               kind      = KIND_SPACE;
               phase_mid = PH_NAME;
            end else begin
               kind      = KIND_MODE;
               phase_mid = PH_MODE;
            end
         end
      endcase

      parse_error = ERR_NONE;
      phase_in    = phase_mid;
      started_in  = started_mid;
      id_count_in = id_count_mid;
      if (stream_last) begin
         priority if (phase_mid == PH_NAME) begin
            parse_error = ERR_NO_TERM;
         end else if (phase_mid == PH_ID) begin
            parse_error = ERR_TRUNC_ID;
         end else if (started_mid) begin
            parse_error = ERR_NO_SPACE;
         end else begin
            parse_error = ERR_NONE;
         end
         phase_in    = PH_MODE;
         started_in  = 1'b0;
         id_count_in = 5'd0;
      end
   end

   assign result.out_byte    = data_byte;
   assign result.field_kind  = kind;
   assign result.entry_end   = entry_end;
   assign result.parse_error = parse_error;
   assign result.stream_done = stream_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_MODE;
         started_ff  <= 1'b0;
         id_count_ff <= 5'd0;
      end else if (step) begin
         phase_ff    <= phase_in;
         started_ff  <= started_in;
         id_count_ff <= id_count_in;
      end
   end

   `TESP_ASSERT_NEXT(a_last_clears, clock, reset, step && stream_last,
      phase_ff == PH_MODE && !started_ff && id_count_ff == 5'd0)
   `TESP_ASSERT_SAME(a_count_in_id, clock, reset, id_count_ff != 5'd0,
      phase_ff == PH_ID && {1'b0, id_count_ff} < IdLast)
   `TESP_ASSERT_SAME(a_end_is_id, clock, reset, step && result.entry_end,
      result.field_kind == KIND_ID)

endmodule

>>> sv/tree_entry_stream_parser_unit.sv
`timescale 1ns / 1ps
`include "tree_entry_stream_parser_unit_defines.svh"
// Parses the content of a tree object streamed one byte per request.
// The req_ channel carries the byte in req_tdata and marks the final byte of
// the object with req_tlast. Every request gives exactly one rsp_ request:
// the same byte, its part of the entry in rsp_tuser, a flag on the last id
// byte of each entry, and on the final byte an error code for an unfinished
// entry, with rsp_tlast echoing the final-byte flag.
// A request is held in an input register and classified on its way into the
// output register, which presents its result.
// One request is taken every cycle unless the output stalls; the rate is set by
// the single phase register that each byte reads and updates.
// When rsp_tready is low, the output register holds its result and the input
// register still takes one more request; req_tready then falls until the
// output drains.
// A synchronous reset empties both registers and returns the parser to the
// start of an entry. After the final byte the parser also returns to the
// start, ready for the next object.
module tree_entry_stream_parser_unit #(
   parameter int ID_BYTES = tesp_pkg::ID_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // stream_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [8] entry_end,
                                    // [10:9] parse_error, [15:11] zero
   output logic [2:0]  rsp_tuser,   // [2:0] field_kind
   output logic        rsp_tlast    // stream_done
);
   import tesp_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       rsp_valid_ff;
   result_type rsp_result_ff;
   result_type fsm_result;
   logic       out_free;
   logic       move;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign move       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   tesp_phase_fsm #(
      .ID_BYTES(ID_BYTES)
   ) u_phase_fsm (
      .clock      (clock),
      .reset      (reset),
      .step       (move),
      .data_byte  (in_byte_ff),
      .stream_last(in_last_ff),
      .result     (fsm_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (move) begin
         rsp_result_ff <= fsm_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_result_ff.parse_error, rsp_result_ff.entry_end,
                        rsp_result_ff.out_byte};
   assign rsp_tuser  = rsp_result_ff.field_kind;
   assign rsp_tlast  = rsp_result_ff.stream_done;

   `TESP_ASSERT_SAME(a_full_stall, clock, reset,
      in_valid_ff && rsp_valid_ff && !rsp_tready, !req_tready)
   `TESP_ASSERT_NEXT(a_move_fills, clock, reset, move, rsp_valid_ff)
   `TESP_ASSERT_SAME(a_err_on_last, clock, reset,
      rsp_valid_ff && rsp_result_ff.parse_error != ERR_NONE, rsp_result_ff.stream_done)

endmodule

>>> test/tree_entry_stream_parser_unit_test.sv
`timescale 1ns / 1ps

module tree_entry_stream_parser_unit_test;
   import tesp_pkg::*;

   localparam int ID_BYTES     = ID_BYTES_DEFAULT;
   localparam int RANDOM_ITEMS = 650;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_last;
   } request_type;

   class tree_parse_scoreboard;
      typedef enum logic [1:0] {PHASE_MODE, PHASE_NAME, PHASE_ID} parse_phase_type;

      parse_phase_type phase;
      bit              entry_started;
      logic [4:0]      id_count;
      result_type      expected_results[$];
      int              mismatch_count;
      int              request_count;
      int              entry_count;
      int              stream_errors[4];

      function new();
         restart();
         mismatch_count = 0;
         request_count = 0;
         entry_count = 0;
         foreach (stream_errors[i]) stream_errors[i] = 0;
      endfunction

      function void restart();
         phase = PHASE_MODE;
         entry_started = 1'b0;
         id_count = '0;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void note_request(logic [7:0] data_byte, logic stream_last);
         result_type r;
         r.out_byte = data_byte;
         r.entry_end = 1'b0;
         r.parse_error = ERR_NONE;
         r.stream_done = stream_last;
         case (phase)
            PHASE_NAME: begin
               if (data_byte == BYTE_ZERO) begin
                  r.field_kind = KIND_ZERO;
                  phase = PHASE_ID;
                  id_count = '0;
               end else begin
                  r.field_kind = KIND_NAME;
               end
            end
            PHASE_ID: begin
               r.field_kind = KIND_ID;
               if (int'(id_count) + 1 >= ID_BYTES) begin
                  r.entry_end = 1'b1;
                  phase = PHASE_MODE;
                  entry_started = 1'b0;
                  id_count = '0;
               end else begin
                  id_count = id_count + 5'd1;
               end
            end
            default: begin
               entry_started = 1'b1;
               if (data_byte == BYTE_SPACE) begin
                  r.field_kind = KIND_SPACE;
                  phase = PHASE_NAME;
               end else begin
                  r.field_kind = KIND_MODE;
                  phase = PHASE_MODE;
               end
            end
         endcase
         if (stream_last) begin
            if (phase == PHASE_NAME) r.parse_error = ERR_NO_TERM;
            else if (phase == PHASE_ID) r.parse_error = ERR_TRUNC_ID;
            else if (entry_started) r.parse_error = ERR_NO_SPACE;
            stream_errors[r.parse_error]++;
            restart();
         end
         if (r.entry_end) entry_count++;
         request_count++;
         expected_results.push_back(r);
      endfunction

      task report_mismatch(string what, int got, int want);
         mismatch_count++;
         $display("mismatch on response %0d: %s got %0h expected %0h",
                  request_count - expected_results.size(), what, got, want);
      endtask

      task check_response(logic [15:0] data, logic [2:0] user, logic last);
         result_type e;
         if (expected_results.size() == 0) begin
            report_mismatch("response with nothing pending, tdata", data, 0);
            return;
         end
         e = expected_results.pop_front();
         if (data[7:0] != e.out_byte) report_mismatch("out_byte", data[7:0], e.out_byte);
         if (user != e.field_kind) report_mismatch("field_kind", user, e.field_kind);
         if (data[8] != e.entry_end) report_mismatch("entry_end", data[8], e.entry_end);
         if (data[10:9] != e.parse_error)
            report_mismatch("parse_error", data[10:9], e.parse_error);
         if (last != e.stream_done) report_mismatch("stream_done", last, e.stream_done);
         if (data[15:11] != 5'd0) report_mismatch("tdata padding", data[15:11], 0);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   tree_parse_scoreboard sb = new();
   request_type object_bytes[$];
   int send_idle_pct = 15;
   int rsp_stall_pct = 47;
   int random_sent = 0;
   int cycle_count = 0;

   tree_entry_stream_parser_unit #(
      .ID_BYTES(ID_BYTES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results pending",
                  cycle_count, sb.pending());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Called at a falling edge; returns at the falling edge after acceptance
   // with req_tvalid still high.
   task automatic send_request(input logic [7:0] data_byte, input logic stream_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data_byte;
      req_tlast <= stream_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_object();
      foreach (object_bytes[i])
         send_request(object_bytes[i].data_byte, object_bytes[i].stream_last);
   endtask

   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   function automatic void push_byte(logic [7:0] data_byte, logic stream_last);
      request_type it;
      it.data_byte = data_byte;
      it.stream_last = stream_last;
      object_bytes.push_back(it);
   endfunction

   function automatic logic [7:0] mode_char();
      logic [7:0] c;
      if ($urandom_range(7) != 0) return 8'h30 + 8'($urandom_range(7));
      do c = 8'($urandom_range(255)); while (c == BYTE_SPACE);
      return c;
   endfunction

   function automatic void push_entry();
      int mode_bytes;
      int name_bytes;
      mode_bytes = $urandom_range(6);
      name_bytes = $urandom_range(8);
      repeat (mode_bytes) push_byte(mode_char(), 1'b0);
      push_byte(BYTE_SPACE, 1'b0);
      repeat (name_bytes) push_byte(8'($urandom_range(255, 1)), 1'b0);
      push_byte(BYTE_ZERO, 1'b0);
      repeat (ID_BYTES) push_byte(8'($urandom_range(255)), 1'b0);
   endfunction

   function automatic void make_random_object();
      int style;
      int cut;
      object_bytes.delete();
      style = $urandom_range(9);
      if (style == 0) begin
         repeat ($urandom_range(12, 1))
            push_byte(8'($urandom_range(255)), ($urandom_range(5) == 0));
      end else begin
         repeat ($urandom_range(3, 1)) push_entry();
         if (style <= 2) begin
            cut = $urandom_range(object_bytes.size(), 1);
            while (object_bytes.size() > cut) void'(object_bytes.pop_back());
         end
      end
      object_bytes[object_bytes.size() - 1].stream_last = 1'b1;
   endfunction

   initial begin
      int stage;
      int new_stage;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Mode byte on the final byte, and a zero byte inside the mode.
      object_bytes.delete();
      push_byte(8'h30, 1'b1);
      push_byte(BYTE_ZERO, 1'b0);
      push_byte(8'hFF, 1'b1);
      // Final byte inside the name, then the zero byte as the final byte.
      push_byte(8'hFF, 1'b0);
      push_byte(BYTE_SPACE, 1'b0);
      push_byte(8'h61, 1'b1);
      push_byte(BYTE_SPACE, 1'b0);
      push_byte(BYTE_ZERO, 1'b1);
      send_object();

      // Empty mode and name, an id holding spaces, zeros and all-ones bytes,
      // closed by the final byte on the last id byte.
      object_bytes.delete();
      push_byte(BYTE_SPACE, 1'b0);
      push_byte(BYTE_ZERO, 1'b0);
      for (int i = 0; i < ID_BYTES; i++) begin
         case (i % 4)
            0: push_byte(BYTE_SPACE, i == ID_BYTES - 1);
            1: push_byte(BYTE_ZERO, i == ID_BYTES - 1);
            2: push_byte(8'hFF, i == ID_BYTES - 1);
            default: push_byte(8'h5A, i == ID_BYTES - 1);
         endcase
      end
      send_object();
      wait_until_drained();

      stage = 0;
      while (random_sent < RANDOM_ITEMS) begin
         new_stage = random_sent * 3 / RANDOM_ITEMS;
         if (new_stage != stage) begin
            stage = new_stage;
            wait_until_drained();
            send_idle_pct = (stage == 1) ? 47 : 0;
            rsp_stall_pct = (stage == 1) ? 15 : 0;
         end else if ($urandom_range(19) == 0) begin
            wait_until_drained();
         end
         make_random_object();
         random_sent += object_bytes.size();
         send_object();
      end

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Checked %0d requests forming %0d complete entries.",
               sb.request_count, sb.entry_count);
      $display("Stream ends: %0d clean, %0d no space, %0d no terminator, %0d truncated id.",
               sb.stream_errors[ERR_NONE], sb.stream_errors[ERR_NO_SPACE],
               sb.stream_errors[ERR_NO_TERM], sb.stream_errors[ERR_TRUNC_ID]);
      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+sv
sv/tesp_pkg.sv
sv/tesp_phase_fsm.sv
sv/tree_entry_stream_parser_unit.sv
test/tree_entry_stream_parser_unit_test.sv
